FILE: hdl/wbdm_pkg.sv
package wbdm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int BANKS      = 6;
    localparam int BANK_W     = 3;
    localparam int PLANES     = 3;
    localparam int TAPS       = 5;
    localparam int SEL_W      = 3;
    localparam int VSUM_W     = 12;
    localparam int JOBQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_HOLD0 = 3'd1;
    localparam logic [2:0] MODE_HOLD1 = 3'd2;
    localparam logic [2:0] MODE_LOAD  = 3'd3;
    localparam logic [2:0] MODE_SHIFT = 3'd4;

    typedef struct packed {
        logic                            wr;
        logic                            do_v;
        logic                            emit;
        logic                            last;
        logic [2:0]                      mode;
        logic [COL_W-1:0]                col;
        logic [BANK_W-1:0]               wbank;
        logic [TAPS-1:0][BANK_W-1:0]     tbank;
        logic [TAPS-1:0]                 tcur;
        logic [TAPS-1:0][SEL_W-1:0]      sel;
        logic [PLANES-1:0][7:0]          gray;
    } t_job;

    typedef struct packed {
        logic       mask_set;
        logic [7:0] model_value;
        logic [7:0] difference;
        logic       frame_last;
    } t_result;

    function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [22:0] s;
        s = 23'(b) * 23'd1868 + 23'(g) * 23'd9617 + 23'(r) * 23'd4899 + 23'd8192;
        return s[21:14];
    endfunction

    function automatic logic signed [12:0] reflect101(input logic signed [12:0] i,
                                                      input logic signed [12:0] n);
        logic signed [12:0] res;
        if (i < 13'sd0) begin
            res = -i;
        end else if (i >= n) begin
            res = (n <<< 1) - 13'sd2 - i;
        end else begin
            res = i;
        end
        return res;
    endfunction

    function automatic logic [BANK_W-1:0] bank_back(input logic [BANK_W-1:0] b,
                                                    input logic [BANK_W-1:0] e);
        logic [3:0] s;
        s = {1'b0, b} + 4'd6 - {1'b0, e};
        if (s >= 4'd6) begin
            s = s - 4'd6;
        end
        return s[BANK_W-1:0];
    endfunction

endpackage

FILE: hdl/wbdm_front.sv
module wbdm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_cmd,
    input  logic [wbdm_pkg::PLANES-1:0][23:0] i_pix,
    input  logic                           i_q_full,
    input  logic                           i_cfg_valid,
    input  logic [wbdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [10:0]                    i_cfg_data,
    output logic                           o_full,
    output logic                           o_job_push,
    output wbdm_pkg::t_job                 o_job,
    output logic [7:0]                     o_threshold
);
    import wbdm_pkg::*;

    logic [7:0]        r_thresh;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [DIM_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [BANK_W-1:0] r_bank;
    logic [DIM_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [BANK_W-1:0] n_bank;
    logic              accept;
    logic              act;
    t_job              job;
    logic [DIM_W-1:0]  cfg_dim;
    logic [DIM_W-1:0]  cfg_hi;

    assign accept = i_push && !i_q_full;

    always_comb begin
        logic               is_pix;
        logic               frame_done;
        logic               drain_ok;
        logic [DIM_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [BANK_W-1:0]  bank;
        logic [DIM_W-1:0]   c_out;
        logic [DIM_W-1:0]   m_col;
        logic signed [12:0] r13;
        logic signed [12:0] h13;
        logic signed [12:0] w13;
        logic signed [12:0] x;
        logic [BANK_W-1:0]  e;
        is_pix     = !i_cmd;
        frame_done = r_row >= r_height;
        drain_ok   = frame_done && !((r_row == r_height + 11'd2) && (r_col >= COL_W'(2)));
        act        = is_pix || drain_ok;
        if (is_pix && frame_done) begin
            row  = '0;
            col  = '0;
            bank = '0;
        end else begin
            row  = r_row;
            col  = r_col;
            bank = r_bank;
        end
        r13 = $signed({2'b00, row});
        h13 = $signed({2'b00, r_height});
        w13 = $signed({2'b00, r_width});

        job.wr    = is_pix;
        job.col   = col;
        job.wbank = bank;
        job.do_v  = (row >= 11'd2) && (row <= r_height + 11'd1);
        job.emit  = (row >= 11'd3) || ((row == 11'd2) && (col >= COL_W'(2)));
        job.last  = (row == r_height + 11'd2) && (col == COL_W'(1));
        for (int p = 0; p < PLANES; p++) begin
            job.gray[p] = to_gray(i_pix[p][7:0], i_pix[p][15:8], i_pix[p][23:16]);
        end

        if (!job.do_v) begin
            job.mode = MODE_NONE;
        end else if (col == COL_W'(0)) begin
            job.mode = MODE_HOLD0;
        end else if (col == COL_W'(1)) begin
            job.mode = MODE_HOLD1;
        end else if (col == COL_W'(2)) begin
            job.mode = MODE_LOAD;
        end else begin
            job.mode = MODE_SHIFT;
        end

        if (col >= COL_W'(2)) begin
            c_out = {1'b0, col} - 11'd2;
            m_col = {1'b0, col};
        end else begin
            c_out = r_width - 11'd2 + {1'b0, col};
            m_col = r_width - 11'd1;
        end
        for (int k = 0; k < TAPS; k++) begin
            x = reflect101($signed({2'b00, c_out}) + 13'(k) - 13'sd2, w13);
            job.sel[k] = SEL_W'(13'sd4 - $signed({2'b00, m_col}) + x);
        end

        for (int j = 0; j < TAPS; j++) begin
            x = reflect101(r13 - 13'(j), h13);
            e = BANK_W'(r13 - x);
            job.tbank[j] = bank_back(bank, e);
            job.tcur[j]  = is_pix && (e == '0);
        end

        if ({1'b0, col} == r_width - 11'd1) begin
            n_col  = '0;
            n_row  = row + 11'd1;
            n_bank = (bank == BANK_W'(BANKS - 1)) ? '0 : bank + BANK_W'(1);
        end else begin
            n_col  = col + COL_W'(1);
            n_row  = row;
            n_bank = bank;
        end
    end

    assign cfg_hi = (i_cfg_index == CFG_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(MAX_WIDTH);

    always_comb begin
        if (i_cfg_data < 11'd3) begin
            cfg_dim = 11'd3;
        end else if (i_cfg_data > cfg_hi) begin
            cfg_dim = cfg_hi;
        end else begin
            cfg_dim = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 8'd30;
            r_width  <= 11'd320;
            r_height <= 11'd240;
            r_row    <= '0;
            r_col    <= '0;
            r_bank   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thresh <= i_cfg_data[7:0];
                CFG_WIDTH: begin
                    r_width <= cfg_dim;
                    r_row   <= '0;
                    r_col   <= '0;
                    r_bank  <= '0;
                end
                CFG_HEIGHT: begin
                    r_height <= cfg_dim;
                    r_row    <= '0;
                    r_col    <= '0;
                    r_bank   <= '0;
                end
                default: ;
            endcase
        end else if (accept && act) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_bank <= n_bank;
        end
    end

    assign o_full      = i_q_full;
    assign o_job_push  = accept && act;
    assign o_job       = job;
    assign o_threshold = r_thresh;

endmodule

FILE: hdl/wbdm_jobq.sv
module wbdm_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbdm_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output wbdm_pkg::t_job o_head
);
    import wbdm_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    t_job             r_data [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(JOBQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

FILE: hdl/wbdm_back.sv
module wbdm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  wbdm_pkg::t_job    i_head,
    input  logic [7:0]        i_threshold,
    input  logic              i_res_pop,
    output logic              o_q_pop,
    output logic              o_res_push,
    output wbdm_pkg::t_result o_res
);
    import wbdm_pkg::*;

    localparam int CRD_W = $clog2(OUTQ_DEPTH + 1);

    logic              issue;
    logic [CRD_W-1:0]  r_credit;
    logic [7:0]        w_rd [BANKS][PLANES];

    logic              r_v1;
    t_job              r_j1;
    logic              r_v2;
    t_job              r_j2;
    logic [VSUM_W-1:0] r_vs [PLANES];
    logic [VSUM_W-1:0] r_s  [PLANES][TAPS];
    logic [VSUM_W-1:0] r_h0 [PLANES];
    logic [VSUM_W-1:0] r_h1 [PLANES];
    logic              r_v3;
    logic              r_last3;
    logic [7:0]        r_g  [PLANES];
    logic              r_v4;
    logic              r_last4;
    logic [6:0]        r_t;
    logic [7:0]        r_g0;
    logic [7:0]        r_g2;

    logic [VSUM_W-1:0] vs  [PLANES];
    logic [VSUM_W-1:0] s_nx [PLANES][TAPS];
    logic [7:0]        g   [PLANES];

    assign issue   = !i_q_empty && (!i_head.emit || (r_credit < CRD_W'(OUTQ_DEPTH)));
    assign o_q_pop = issue;

    for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
        for (genvar gp = 0; gp < PLANES; gp++) begin : g_plane
            logic [7:0] r_mem [MAX_WIDTH];
            logic [7:0] r_rd;
            always_ff @(posedge i_clk) begin
                if (issue) begin
                    if (i_head.wr && (i_head.wbank == BANK_W'(gb))) begin
                        r_mem[i_head.col] <= i_head.gray[gp];
                    end
                    r_rd <= r_mem[i_head.col];
                end
            end
            assign w_rd[gb][gp] = r_rd;
        end
    end

    // vertical five-tap column sum
    always_comb begin
        logic [7:0] a [TAPS];
        for (int p = 0; p < PLANES; p++) begin
            for (int j = 0; j < TAPS; j++) begin
                a[j] = r_j1.gray[p];
                if (!r_j1.tcur[j]) begin
                    a[j] = '0;
                    for (int b = 0; b < BANKS; b++) begin
                        if (r_j1.tbank[j] == BANK_W'(b)) begin
                            a[j] = w_rd[b][p];
                        end
                    end
                end
            end
            vs[p] = VSUM_W'(a[0]) + (VSUM_W'(a[1]) << 2) + VSUM_W'(a[2]) * VSUM_W'(6)
                  + (VSUM_W'(a[3]) << 2) + VSUM_W'(a[4]);
        end
    end

    // horizontal window and blur
    always_comb begin
        logic [VSUM_W-1:0] w [TAPS];
        logic [15:0]       hs;
        for (int p = 0; p < PLANES; p++) begin
            for (int k = 0; k < TAPS; k++) begin
                s_nx[p][k] = r_s[p][k];
            end
            unique case (r_j2.mode)
                MODE_LOAD: begin
                    s_nx[p][0] = r_s[p][2];
                    s_nx[p][1] = r_s[p][3];
                    s_nx[p][2] = r_h0[p];
                    s_nx[p][3] = r_h1[p];
                    s_nx[p][4] = r_vs[p];
                end
                MODE_SHIFT: begin
                    for (int k = 0; k < TAPS - 1; k++) begin
                        s_nx[p][k] = r_s[p][k+1];
                    end
                    s_nx[p][TAPS-1] = r_vs[p];
                end
                default: ;
            endcase
            for (int k = 0; k < TAPS; k++) begin
                w[k] = '0;
                for (int q = 0; q < TAPS; q++) begin
                    if (r_j2.sel[k] == SEL_W'(q)) begin
                        w[k] = s_nx[p][q];
                    end
                end
            end
            hs = 16'(w[0]) + (16'(w[1]) << 2) + 16'(w[2]) * 16'd6 + (16'(w[3]) << 2)
               + 16'(w[4]) + 16'd128;
            g[p] = hs[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1 <= i_head;
        r_j2 <= r_j1;
        for (int p = 0; p < PLANES; p++) begin
            r_vs[p] <= vs[p];
            r_g[p]  <= g[p];
        end
        r_last3 <= r_j2.last;
        r_t     <= 7'(({2'b00, r_g[0]} + {1'b0, r_g[1], 1'b0} + 10'd5) * 24'd6554 >> 16);
        r_g0    <= r_g[0];
        r_g2    <= r_g[2];
        r_last4 <= r_last3;
        if (r_v2) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int k = 0; k < TAPS; k++) begin
                    r_s[p][k] <= s_nx[p][k];
                end
                if (r_j2.mode == MODE_HOLD0) begin
                    r_h0[p] <= r_vs[p];
                end
                if (r_j2.mode == MODE_HOLD1) begin
                    r_h1[p] <= r_vs[p];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_credit <= '0;
        end else begin
            r_v1     <= issue;
            r_v2     <= r_v1;
            r_v3     <= r_v2 && r_j2.emit;
            r_v4     <= r_v3;
            r_credit <= r_credit + CRD_W'(issue && i_head.emit) - CRD_W'(i_res_pop);
        end
    end

    // background model, difference and mask
    always_comb begin
        logic [11:0] y;
        logic [24:0] prod;
        logic [8:0]  bgq;
        logic [7:0]  bg;
        logic [7:0]  diff;
        y    = 12'(r_t) * 12'd10 + 12'(r_g2) * 12'd7 + 12'd5;
        prod = 25'(y) * 25'd6554;
        bgq  = prod[24:16];
        bg   = (bgq > 9'd255) ? 8'd255 : bgq[7:0];
        diff = (r_g0 > bg) ? r_g0 - bg : bg - r_g0;
        o_res.mask_set    = diff > i_threshold;
        o_res.model_value = bg;
        o_res.difference  = diff;
        o_res.frame_last  = r_last4;
    end

    assign o_res_push = r_v4;

endmodule

FILE: hdl/wbdm_outq.sv
module wbdm_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wbdm_pkg::t_result i_res,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output wbdm_pkg::t_result o_head
);
    import wbdm_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    t_result          r_data [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(OUTQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

FILE: hdl/weighted_background_difference_mask_unit.sv
// a result passes line store read, sum, blur and model registers, then the output queue
// throughput: one item per cycle while no queue stalls, bounded by one port per line store
// results trail pixels by 2*width+2 positions; drain items release the last ones
// reset: synchronous active low, clears queues and frame position, restores registers
// line stores need no clearing pass after reset
module weighted_background_difference_mask_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_blue_zero,
    input  logic [7:0]                     i_green_zero,
    input  logic [7:0]                     i_red_zero,
    input  logic [7:0]                     i_blue_one,
    input  logic [7:0]                     i_green_one,
    input  logic [7:0]                     i_red_one,
    input  logic [7:0]                     i_blue_two,
    input  logic [7:0]                     i_green_two,
    input  logic [7:0]                     i_red_two,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wbdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [10:0]                    i_cfg_data,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_mask_set,
    output logic [7:0]                     o_model_value,
    output logic [7:0]                     o_difference,
    output logic                           o_frame_last
);
    import wbdm_pkg::*;

    logic                     jobq_full;
    logic                     jobq_empty;
    logic                     job_push;
    logic                     job_pop;
    t_job                     job;
    t_job                     job_head;
    logic [7:0]               threshold;
    logic                     res_push;
    t_result                  res;
    t_result                  res_head;
    logic                     outq_full;
    logic                     res_pop;
    logic [PLANES-1:0][23:0]  pix;

    assign pix[0] = {i_red_zero, i_green_zero, i_blue_zero};
    assign pix[1] = {i_red_one, i_green_one, i_blue_one};
    assign pix[2] = {i_red_two, i_green_two, i_blue_two};

    assign o_cfg_ready = 1'b1;
    assign res_pop     = pop && !empty;

    wbdm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (i_cmd),
        .i_pix       (pix),
        .i_q_full    (jobq_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job),
        .o_threshold (threshold)
    );

    wbdm_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .i_pop   (job_pop),
        .o_full  (jobq_full),
        .o_empty (jobq_empty),
        .o_head  (job_head)
    );

    wbdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (jobq_empty),
        .i_head      (job_head),
        .i_threshold (threshold),
        .i_res_pop   (res_pop),
        .o_q_pop     (job_pop),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    wbdm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .i_pop   (res_pop),
        .o_full  (outq_full),
        .o_empty (empty),
        .o_head  (res_head)
    );

    assign o_mask_set    = res_head.mask_set;
    assign o_model_value = res_head.model_value;
    assign o_difference  = res_head.difference;
    assign o_frame_last  = res_head.frame_last;

    a_outq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !outq_full)
        else $error("result written into full output queue");

    a_jobq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !jobq_full)
        else $error("request written into full job queue");

    a_pop_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !jobq_empty)
        else $error("job taken from empty queue");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("result pending right after reset");

endmodule
